>>> src/ebjp_pkg.sv
package ebjp_pkg;

    localparam int WAIT_DEPTH_DEF = 64;
    localparam int RUN_DEPTH_DEF  = 64;

    // Operation codes
    localparam logic [1:0] OP_ADD_WAIT = 2'd0;
    localparam logic [1:0] OP_ADD_RUN  = 2'd1;
    localparam logic [1:0] OP_DEL_RUN  = 2'd2;
    localparam logic [1:0] OP_PICK     = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Wait order policies (anything else is arrival order)
    localparam logic [1:0] POL_SJF = 2'd1;
    localparam logic [1:0] POL_LJF = 2'd2;

    // Register select, taken from paddr[2]
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_MODE   = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [23:0] job_id;
        logic [15:0] job_nodes;
        logic [39:0] event_time;
        logic [31:0] limit_time;
        logic [31:0] actual_duration;
        logic [15:0] idle_nodes;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        picked_valid;
        logic [23:0] picked_job;
        logic        picked_by_backfill;
        logic [39:0] reservation_time;
    } t_out;

    // One stored job: submit time for waiting jobs, start time for running jobs
    typedef struct packed {
        logic [23:0] job;
        logic [39:0] tstamp;
        logic [15:0] need;
        logic [31:0] limit;
        logic [31:0] actual;
    } t_entry;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD,
        S_FIND_RD,
        S_FIND_EV,
        S_RUN_WR,
        S_HEAD_RD,
        S_HEAD_EV,
        S_HEAD_DEC,
        S_RO_RD,
        S_RO_EV,
        S_RI_RD,
        S_RI_EV,
        S_RO_END,
        S_RES,
        S_BF_RD,
        S_BF_EV,
        S_BF_DEC,
        S_COMMIT,
        S_RECLAIM,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic wait_wr;
        logic find_ev;
        logic run_wr;
        logic head_ev;
        logic ro_ev;
        logic ri_ev;
        logic ro_end;
        logic res_fin;
        logic bf_ev;
        logic commit;
        logic reclaim;
        logic out_ld;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       span_zero;
        logic       k_last;
        logic       j_last;
        logic       i_last;
        logic       have_head;
        logic       head_fits;
        logic       ro_ok;
        logic       bf_found;
        logic       reclaim_done;
        logic       out_free;
    } t_stat;

endpackage

>>> src/ebjp_ctrl.sv
module ebjp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ebjp_pkg::t_stat  i_stat,
    output ebjp_pkg::t_cmd   o_cmd
);
    import ebjp_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:     if (i_in_valid) n_state = S_DISPATCH;
            S_DISPATCH: begin
                unique case (i_stat.op)
                    OP_ADD_WAIT: n_state = S_ADD;
                    OP_ADD_RUN,
                    OP_DEL_RUN:  n_state = S_FIND_RD;
                    default:     n_state = i_stat.span_zero ? S_OUT : S_HEAD_RD;
                endcase
            end
            S_ADD:      n_state = S_OUT;
            S_FIND_RD:  n_state = S_FIND_EV;
            S_FIND_EV:  n_state = i_stat.j_last ? S_RUN_WR : S_FIND_RD;
            S_RUN_WR:   n_state = S_OUT;
            S_HEAD_RD:  n_state = S_HEAD_EV;
            S_HEAD_EV:  n_state = i_stat.k_last ? S_HEAD_DEC : S_HEAD_RD;
            S_HEAD_DEC: begin
                priority if (!i_stat.have_head) n_state = S_OUT;
                else if (i_stat.head_fits)      n_state = S_COMMIT;
                else                            n_state = S_RO_RD;
            end
            S_RO_RD:    n_state = S_RO_EV;
            S_RO_EV:    n_state = i_stat.ro_ok ? S_RI_RD : S_RO_END;
            S_RI_RD:    n_state = S_RI_EV;
            S_RI_EV:    n_state = i_stat.j_last ? S_RO_END : S_RI_RD;
            S_RO_END:   n_state = i_stat.i_last ? S_RES : S_RO_RD;
            S_RES:      n_state = S_BF_RD;
            S_BF_RD:    n_state = S_BF_EV;
            S_BF_EV:    n_state = i_stat.k_last ? S_BF_DEC : S_BF_RD;
            S_BF_DEC:   n_state = i_stat.bf_found ? S_COMMIT : S_OUT;
            S_COMMIT:   n_state = S_RECLAIM;
            S_RECLAIM:  if (i_stat.reclaim_done) n_state = S_OUT;
            S_OUT:      if (i_stat.out_free) n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_ADD:     o_cmd.wait_wr = 1'b1;
            S_FIND_EV: o_cmd.find_ev = 1'b1;
            S_RUN_WR:  o_cmd.run_wr  = 1'b1;
            S_HEAD_EV: o_cmd.head_ev = 1'b1;
            S_RO_EV:   o_cmd.ro_ev   = 1'b1;
            S_RI_EV:   o_cmd.ri_ev   = 1'b1;
            S_RO_END:  o_cmd.ro_end  = 1'b1;
            S_RES:     o_cmd.res_fin = 1'b1;
            S_BF_EV:   o_cmd.bf_ev   = 1'b1;
            S_COMMIT:  o_cmd.commit  = 1'b1;
            S_RECLAIM: o_cmd.reclaim = !i_stat.reclaim_done;
            S_OUT:     o_cmd.out_ld  = i_stat.out_free;
            default: ;
        endcase
    end

endmodule

>>> src/ebjp_dp.sv
module ebjp_dp #(
    parameter int WAIT_DEPTH = ebjp_pkg::WAIT_DEPTH_DEF,
    parameter int RUN_DEPTH  = ebjp_pkg::RUN_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ebjp_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ebjp_pkg::t_out   o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  ebjp_pkg::t_cmd   i_cmd,
    output ebjp_pkg::t_stat  o_stat
);
    import ebjp_pkg::*;

    localparam int WSW = $clog2(WAIT_DEPTH);
    localparam int PW  = $clog2(2 * WAIT_DEPTH);
    localparam int RAW = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int SW  = 17 + RAW;

    // Ring pointer to slot
    function automatic logic [WSW-1:0] f_slot(input logic [PW-1:0] p);
        logic [PW-1:0] d;
        d = (p >= PW'(WAIT_DEPTH)) ? p - PW'(WAIT_DEPTH) : p;
        return d[WSW-1:0];
    endfunction

    // Configuration
    logic [1:0] r_policy;
    logic       r_mode;

    // Stores
    t_entry r_wait_mem [WAIT_DEPTH];
    t_entry r_run_mem  [RUN_DEPTH];
    logic [WAIT_DEPTH-1:0] r_wait_live;
    logic [RUN_DEPTH-1:0]  r_run_live;
    logic [PW-1:0] r_head;
    logic [PW-1:0] r_tail;
    logic [39:0]   r_held;

    // Item and scan state
    t_in            r_item;
    t_entry         r_wrd;
    t_entry         r_rd_i;
    t_entry         r_rd_j;
    logic [PW-1:0]  r_k;
    logic [WSW-1:0] r_slot;
    logic [RAW-1:0] r_i;
    logic [RAW-1:0] r_j;

    logic           r_have;
    logic [WSW-1:0] r_hslot;
    logic [31:0]    r_hest;
    logic [15:0]    r_hneed;
    logic [23:0]    r_hjob;
    logic           r_bf;
    logic [WSW-1:0] r_cslot;
    logic [31:0]    r_best_e;
    logic [23:0]    r_cjob;

    logic           r_match_ok;
    logic [RAW-1:0] r_match;
    logic           r_free_ok;
    logic [RAW-1:0] r_free;

    logic [40:0]    r_ei;
    logic           r_ovalid;
    logic [SW-1:0]  r_sum;
    logic           r_found;
    logic [40:0]    r_res_best;
    logic [40:0]    r_res;

    logic [1:0]     r_status;
    logic           r_pvalid;
    logic [23:0]    r_pjob;
    logic           r_pbf;

    logic           r_ov;
    t_out           r_out;

    // Derived values
    logic [PW:0]    span_wrap;
    logic [PW-1:0]  span;
    logic [PW-1:0]  next_tail;
    logic [PW-1:0]  next_head;
    logic [WSW-1:0] tail_slot;
    logic [WSW-1:0] head_slot;
    logic [WSW-1:0] next_slot;
    logic [31:0]    w_est;
    logic [31:0]    i_est;
    logic [31:0]    j_est;
    logic [40:0]    now41;
    logic [40:0]    ei_now;
    logic [40:0]    ej_now;
    logic [40:0]    bf_end;
    logic [40:0]    res_pick;
    logic           w_elig;
    logic           rank_h;
    logic           rank_b;
    logic           bf_ok;
    logic           rj_counts;
    logic [WSW-1:0] pick_slot;
    logic [RAW-1:0] run_slot;
    logic           cfg_wr;

    assign span_wrap = {1'b0, r_tail} + (PW+1)'(2 * WAIT_DEPTH) - {1'b0, r_head};
    assign span      = (r_tail >= r_head) ? r_tail - r_head : span_wrap[PW-1:0];
    assign next_tail = (r_tail == PW'(2 * WAIT_DEPTH - 1)) ? '0 : r_tail + 1'b1;
    assign next_head = (r_head == PW'(2 * WAIT_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign tail_slot = f_slot(r_tail);
    assign head_slot = f_slot(r_head);
    assign next_slot = (r_slot == WSW'(WAIT_DEPTH - 1)) ? '0 : r_slot + 1'b1;

    assign w_est  = r_mode ? r_wrd.actual : r_wrd.limit;
    assign i_est  = r_mode ? r_rd_i.actual : r_rd_i.limit;
    assign j_est  = r_mode ? r_rd_j.actual : r_rd_j.limit;
    assign now41  = {1'b0, r_item.event_time};
    assign ei_now = {1'b0, r_rd_i.tstamp} + {9'b0, i_est};
    assign ej_now = {1'b0, r_rd_j.tstamp} + {9'b0, j_est};
    assign bf_end = now41 + {9'b0, w_est};

    // Reservation once the outer pass is over
    assign res_pick = r_found ? r_res_best : now41;

    // Eligible waiting entry and rank against current best
    assign w_elig = r_wait_live[r_slot] && (r_wrd.tstamp <= r_item.event_time);
    assign rank_h = !r_have || (r_policy == POL_SJF && w_est < r_hest)
                    || (r_policy == POL_LJF && w_est > r_hest);
    assign rank_b = !r_bf || (r_policy == POL_SJF && w_est < r_best_e)
                    || (r_policy == POL_LJF && w_est > r_best_e);
    assign bf_ok  = w_elig && (r_slot != r_hslot)
                    && (r_wrd.need <= r_item.idle_nodes) && (bf_end < r_res);
    assign rj_counts = r_run_live[r_j] && (ej_now > now41) && (ej_now <= r_ei);

    assign pick_slot = r_bf ? r_cslot : r_hslot;
    assign run_slot  = r_match_ok ? r_match : r_free;

    // Status
    assign o_stat.op           = r_item.op;
    assign o_stat.span_zero    = (span == '0);
    assign o_stat.k_last       = (r_k + 1'b1) == span;
    assign o_stat.j_last       = (r_j == RAW'(RUN_DEPTH - 1));
    assign o_stat.i_last       = (r_i == RAW'(RUN_DEPTH - 1));
    assign o_stat.have_head    = r_have;
    assign o_stat.head_fits    = (r_hneed <= r_item.idle_nodes);
    assign o_stat.ro_ok        = r_run_live[r_i] && (ei_now > now41);
    assign o_stat.bf_found     = r_bf;
    assign o_stat.reclaim_done = (r_head == r_tail) || r_wait_live[head_slot];
    assign o_stat.out_free     = !r_ov || !i_out_stall;

    // APB configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POLICY) ? {30'b0, r_policy} : {31'b0, r_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= '0;
            r_mode   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_POLICY: r_policy <= pwdata[1:0];
                REG_MODE:   r_mode   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Memories: one write, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wait_wr && span < PW'(WAIT_DEPTH)) begin
            r_wait_mem[tail_slot] <= '{job: r_item.job_id, tstamp: r_item.event_time,
                                       need: r_item.job_nodes, limit: r_item.limit_time,
                                       actual: r_item.actual_duration};
        end
        r_wrd <= r_wait_mem[r_slot];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.run_wr && r_item.op == OP_ADD_RUN && (r_match_ok || r_free_ok)) begin
            r_run_mem[run_slot] <= '{job: r_item.job_id, tstamp: r_item.event_time,
                                     need: r_item.job_nodes, limit: r_item.limit_time,
                                     actual: r_item.actual_duration};
        end
        r_rd_i <= r_run_mem[r_i];
        r_rd_j <= r_run_mem[r_j];
    end

    // Valid bits, ring pointers, held reservation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_live <= '0;
            r_run_live  <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_held      <= '0;
        end else begin
            if (i_cmd.wait_wr && span < PW'(WAIT_DEPTH)) begin
                r_wait_live[tail_slot] <= 1'b1;
                r_tail                 <= next_tail;
            end
            if (i_cmd.run_wr) begin
                if (r_item.op == OP_DEL_RUN) begin
                    if (r_match_ok) r_run_live[r_match] <= 1'b0;
                end else if (r_match_ok || r_free_ok) begin
                    r_run_live[run_slot] <= 1'b1;
                end
            end
            if (i_cmd.res_fin) begin
                r_held <= res_pick[40] ? '1 : res_pick[39:0];
            end
            if (i_cmd.commit) r_wait_live[pick_slot] <= 1'b0;
            if (i_cmd.reclaim) r_head <= next_head;
        end
    end

    // Item capture and scan engine
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item     <= i_in_data;
            r_k        <= '0;
            r_slot     <= head_slot;
            r_i        <= '0;
            r_j        <= '0;
            r_have     <= 1'b0;
            r_bf       <= 1'b0;
            r_match_ok <= 1'b0;
            r_free_ok  <= 1'b0;
            r_found    <= 1'b0;
            r_status   <= ST_DONE;
            r_pvalid   <= 1'b0;
            r_pjob     <= '0;
            r_pbf      <= 1'b0;
        end
        if (i_cmd.wait_wr && span >= PW'(WAIT_DEPTH)) r_status <= ST_FULL;

        // Running table lookup
        if (i_cmd.find_ev) begin
            if (!r_match_ok && r_run_live[r_j] && r_rd_j.job == r_item.job_id) begin
                r_match_ok <= 1'b1;
                r_match    <= r_j;
            end
            if (!r_free_ok && !r_run_live[r_j]) begin
                r_free_ok <= 1'b1;
                r_free    <= r_j;
            end
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.run_wr) begin
            if (r_item.op == OP_DEL_RUN) begin
                if (!r_match_ok) r_status <= ST_NOT_FOUND;
            end else if (!r_match_ok && !r_free_ok) begin
                r_status <= ST_FULL;
            end
        end

        // Head search
        if (i_cmd.head_ev) begin
            if (w_elig && rank_h) begin
                r_have  <= 1'b1;
                r_hslot <= r_slot;
                r_hest  <= w_est;
                r_hneed <= r_wrd.need;
                r_hjob  <= r_wrd.job;
            end
            r_k    <= r_k + 1'b1;
            r_slot <= next_slot;
        end

        // Reservation: outer running entry
        if (i_cmd.ro_ev) begin
            r_ei     <= ei_now;
            r_ovalid <= o_stat.ro_ok;
            r_sum    <= SW'(r_item.idle_nodes);
            r_j      <= '0;
        end
        // Inner pass adds nodes freed by that time
        if (i_cmd.ri_ev) begin
            if (rj_counts) r_sum <= r_sum + SW'(r_rd_j.need);
            r_j <= r_j + 1'b1;
        end
        if (i_cmd.ro_end) begin
            if (r_ovalid && r_sum >= SW'(r_hneed) && (!r_found || r_ei < r_res_best)) begin
                r_found    <= 1'b1;
                r_res_best <= r_ei;
            end
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.res_fin) begin
            r_res  <= res_pick;
            r_k    <= '0;
            r_slot <= head_slot;
        end

        // Backfill search
        if (i_cmd.bf_ev) begin
            if (bf_ok && rank_b) begin
                r_bf     <= 1'b1;
                r_cslot  <= r_slot;
                r_best_e <= w_est;
                r_cjob   <= r_wrd.job;
            end
            r_k    <= r_k + 1'b1;
            r_slot <= next_slot;
        end

        if (i_cmd.commit) begin
            r_pvalid <= 1'b1;
            r_pjob   <= r_bf ? r_cjob : r_hjob;
            r_pbf    <= r_bf;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_ld) begin
            r_out <= '{status: r_status, picked_valid: r_pvalid, picked_job: r_pjob,
                       picked_by_backfill: r_pbf, reservation_time: r_held};
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    // Checks
    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        span <= PW'(WAIT_DEPTH))
        else $error("ring span exceeds depth");

    a_commit_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> r_wait_live[pick_slot])
        else $error("picked slot not live");

    a_bf_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.picked_by_backfill |-> r_out.picked_valid)
        else $error("backfill flag without pick");

    a_pick_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_out.picked_valid |-> r_out.status == ST_DONE)
        else $error("pick with error status");

endmodule

>>> src/easy_backfill_job_picker.sv
// EASY backfilling job picker.
// Input channel (i_in_valid / o_in_stall / i_in_data) takes one transaction
// per operation: add waiting job, add running job, remove running job, or
// pick a job. Every transaction produces exactly one result on the output
// channel (o_out_valid / i_out_stall / o_out_data).
// Configuration (wait order, runtime estimate source) is to be written over the
// APB port only while idle; the block does not enforce it; pready is always high.
// Work per transaction:
//   add waiting job   a write at the ring tail
//   add/remove run    a lookup pass over the running table
//   pick              a head search over the ring; if the head does not fit,
//                     a nested pass over the running table (one port read
//                     per entry) and a backfill search; a reclaim after a pick.
// One transaction is worked on at a time; no new one is taken before it ends.
// Reset (synchronous, active low) empties the ring and the running table,
// clears the held reservation and both configuration registers.
// A result waits in the output register while i_out_stall is high; the
// next transaction is taken meanwhile and its result waits in turn.
module easy_backfill_job_picker #(
    parameter int WAIT_DEPTH = ebjp_pkg::WAIT_DEPTH_DEF,
    parameter int RUN_DEPTH  = ebjp_pkg::RUN_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ebjp_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output ebjp_pkg::t_out   o_out_data,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ebjp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    ebjp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ebjp_dp #(
        .WAIT_DEPTH (WAIT_DEPTH),
        .RUN_DEPTH  (RUN_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

>>> test/tb.sv
module tb;
    import ebjp_pkg::*;

    localparam int WD = 64;
    localparam int RD = 64;
    localparam logic [40:0] T40_MAX = 41'h0FF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int error_count = 0;
    bit rx_enable = 0;
    int stall_left = 0;

    easy_backfill_job_picker DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Scheduler shadow: waiting ring, running table and expected results
    class picker_scoreboard;
        logic [1:0]  policy;
        logic        mode;
        logic        w_live [WD];
        t_entry      w_job [WD];
        int unsigned head_ptr, tail_ptr;
        logic        r_live [RD];
        t_entry      r_job [RD];
        logic [39:0] held_res;
        t_out        pending[$];

        function void clear();
            policy = 0; mode = 0; head_ptr = 0; tail_ptr = 0; held_res = 0;
            foreach (w_live[i]) w_live[i] = 0;
            foreach (r_live[i]) r_live[i] = 0;
            pending.delete();
        endfunction

        function int unsigned span();
            return (tail_ptr + 2 * WD - head_ptr) % (2 * WD);
        endfunction

        function logic [31:0] est(t_entry e);
            return mode ? e.actual : e.limit;
        endfunction

        function bit ahead(logic [31:0] ea, int pa, logic [31:0] eb, int pb);
            if (policy == POL_SJF && ea != eb) return ea < eb;
            if (policy == POL_LJF && ea != eb) return ea > eb;
            return pa < pb;
        endfunction

        function logic [40:0] reserve(logic [15:0] need, logic [15:0] fr, logic [39:0] now);
            bit found = 0;
            logic [40:0] best = 0, ei, ej;
            logic [31:0] sum;
            for (int i = 0; i < RD; i++) begin
                if (!r_live[i]) continue;
                ei = r_job[i].tstamp + est(r_job[i]);
                if (ei <= now) continue;
                sum = fr;
                for (int j = 0; j < RD; j++) begin
                    if (!r_live[j]) continue;
                    ej = r_job[j].tstamp + est(r_job[j]);
                    if (ej > now && ej <= ei) sum += r_job[j].need;
                end
                if (sum >= need && (!found || ei < best)) begin
                    found = 1;
                    best = ei;
                end
            end
            return found ? best : {1'b0, now};
        endfunction

        function void note_input(t_in x);
            t_out r;
            t_entry e;
            int slot, hs, hp, cs, bp;
            bit have, chosen, bf;
            logic [31:0] hest, best, ev;
            logic [40:0] res;
            r = '0;
            e.job = x.job_id; e.tstamp = x.event_time; e.need = x.job_nodes;
            e.limit = x.limit_time; e.actual = x.actual_duration;
            case (x.op)
                OP_ADD_WAIT: begin
                    if (span() >= WD) r.status = ST_FULL;
                    else begin
                        w_live[tail_ptr % WD] = 1;
                        w_job[tail_ptr % WD] = e;
                        tail_ptr = (tail_ptr + 1) % (2 * WD);
                    end
                end
                OP_ADD_RUN, OP_DEL_RUN: begin
                    slot = RD;
                    for (int i = 0; i < RD; i++)
                        if (r_live[i] && r_job[i].job == x.job_id) begin
                            slot = i;
                            break;
                        end
                    if (x.op == OP_DEL_RUN) begin
                        if (slot < RD) r_live[slot] = 0;
                        else r.status = ST_NOT_FOUND;
                    end else begin
                        if (slot >= RD)
                            for (int i = 0; i < RD; i++)
                                if (!r_live[i]) begin
                                    slot = i;
                                    break;
                                end
                        if (slot >= RD) r.status = ST_FULL;
                        else begin
                            r_live[slot] = 1;
                            r_job[slot] = e;
                        end
                    end
                end
                default: begin
                    have = 0; hs = 0; hp = 0; hest = 0; chosen = 0; cs = 0;
                    for (int k = 0; k < span(); k++) begin
                        slot = (head_ptr + k) % WD;
                        if (!w_live[slot] || w_job[slot].tstamp > x.event_time) continue;
                        ev = est(w_job[slot]);
                        if (!have || ahead(ev, k, hest, hp)) begin
                            have = 1; hs = slot; hp = k; hest = ev;
                        end
                    end
                    if (have) begin
                        if (w_job[hs].need <= x.idle_nodes) begin
                            chosen = 1; cs = hs;
                        end else begin
                            res = reserve(w_job[hs].need, x.idle_nodes, x.event_time);
                            held_res = (res > T40_MAX) ? T40_MAX[39:0] : res[39:0];
                            bf = 0; bp = 0; best = 0;
                            for (int k = 0; k < span(); k++) begin
                                slot = (head_ptr + k) % WD;
                                if (slot == hs || !w_live[slot]) continue;
                                if (w_job[slot].tstamp > x.event_time) continue;
                                if (w_job[slot].need > x.idle_nodes) continue;
                                ev = est(w_job[slot]);
                                if ({1'b0, x.event_time} + ev >= res) continue;
                                if (!bf || ahead(ev, k, best, bp)) begin
                                    bf = 1; cs = slot; bp = k; best = ev;
                                end
                            end
                            if (bf) begin
                                chosen = 1;
                                r.picked_by_backfill = 1;
                            end
                        end
                    end
                    if (chosen) begin
                        r.picked_valid = 1;
                        r.picked_job = w_job[cs].job;
                        w_live[cs] = 0;
                        while (head_ptr != tail_ptr && !w_live[head_ptr % WD])
                            head_ptr = (head_ptr + 1) % (2 * WD);
                    end
                end
            endcase
            r.reservation_time = held_res;
            pending = {pending, r};
        endfunction

        task check_result(t_out got);
            t_out want;
            if (pending.size() == 0) begin
                report("unexpected result", 64'(got), 64'd0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report("status", 64'(got.status), 64'(want.status));
            if (got.picked_valid !== want.picked_valid)
                report("picked_valid", 64'(got.picked_valid), 64'(want.picked_valid));
            if (got.picked_job !== want.picked_job)
                report("picked_job", 64'(got.picked_job), 64'(want.picked_job));
            if (got.picked_by_backfill !== want.picked_by_backfill)
                report("picked_by_backfill", 64'(got.picked_by_backfill),
                       64'(want.picked_by_backfill));
            if (got.reservation_time !== want.reservation_time)
                report("reservation_time", 64'(got.reservation_time),
                       64'(want.reservation_time));
        endtask
    endclass

    picker_scoreboard sched;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #400000000;
        $display("status: fail");
        $finish;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        if ($urandom_range(0, 9) < 5) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result side: random stall runs, check on every accepted transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) sched.check_result(o_out_data);
        if (!rx_enable) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 9) < 3) begin
            stall_left = gap_len();
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send(input t_in x);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sched.note_input(x);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        if (idx == REG_POLICY) sched.policy = val[1:0];
        else sched.mode = val[0];
    endtask

    task automatic drain();
        int n = 0;
        i_in_valid <= 1'b0;
        while (sched.pending.size() != 0 && n < 20000000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in mk(logic [1:0] op, logic [23:0] id, logic [15:0] nodes,
                               logic [39:0] t, logic [31:0] lim, logic [31:0] act,
                               logic [15:0] fr);
        t_in x;
        x.op = op; x.job_id = id; x.job_nodes = nodes; x.event_time = t;
        x.limit_time = lim; x.actual_duration = act; x.idle_nodes = fr;
        return x;
    endfunction

    // Random transaction: mostly small ids/times so jobs collide and interact
    function automatic t_in rand_item();
        t_in x;
        int sel;
        logic [191:0] rnd;
        rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        x = rnd[$bits(t_in)-1:0];
        sel = $urandom_range(0, 9);
        x.op = (sel < 4) ? OP_ADD_WAIT : (sel < 6) ? OP_ADD_RUN :
               (sel < 7) ? OP_DEL_RUN : OP_PICK;
        if ($urandom_range(0, 9) < 8) begin
            x.job_id = 24'($urandom_range(0, 15));
            x.job_nodes = 16'($urandom_range(0, 40));
            x.event_time = 40'($urandom_range(0, 4000));
            x.limit_time = 32'($urandom_range(0, 2000));
            x.actual_duration = 32'($urandom_range(0, 2000));
            x.idle_nodes = 16'($urandom_range(0, 40));
        end
        return x;
    endfunction

    initial begin
        t_in x;
        sched = new();
        sched.clear();
        i_rst_n = 0; i_in_valid = 0; i_in_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        rx_enable = 1;

        // Directed: empty pick, unknown remove, extremes, backfill, overflow
        send(mk(OP_PICK, 0, 0, 40'd100, 0, 0, 16'hFFFF));
        send(mk(OP_DEL_RUN, 24'hFFFFFF, 0, 0, 0, 0, 0));
        send(mk(OP_ADD_RUN, 24'd7, 16'd10, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 0));
        send(mk(OP_ADD_RUN, 24'd7, 16'd10, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'd5, 0));
        send(mk(OP_ADD_RUN, 24'd8, 16'd5, 40'd0, 32'd500, 32'd300, 0));
        send(mk(OP_ADD_WAIT, 24'd1, 16'd30, 40'd0, 32'd100, 32'd50, 0));
        send(mk(OP_ADD_WAIT, 24'd2, 16'd4, 40'd0, 32'd100, 32'd900, 0));
        send(mk(OP_ADD_WAIT, 24'hFFFFFF, 16'hFFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 0));
        send(mk(OP_PICK, 0, 0, 40'd10, 0, 0, 16'd20));
        send(mk(OP_PICK, 0, 0, 40'd10, 0, 0, 16'd20));
        send(mk(OP_ADD_WAIT, 24'd3, 16'd0, 40'd0, 0, 0, 0));
        send(mk(OP_PICK, 0, 0, 40'd10, 0, 0, 16'd0));
        send(mk(OP_PICK, 0, 0, 40'hFF_FFFF_FFFF, 0, 0, 16'hFFFF));
        send(mk(OP_DEL_RUN, 24'd8, 0, 0, 0, 0, 0));
        send(mk(OP_DEL_RUN, 24'd7, 0, 0, 0, 0, 0));
        drain();

        // Fill the ring past its capacity
        for (int i = 0; i < WD + 1; i++)
            send(mk(OP_ADD_WAIT, 24'(i), 16'd100, 40'd0, 32'(i), 32'(64 - i), 16'd0));
        send(mk(OP_PICK, 0, 0, 40'd20, 0, 0, 16'd100));
        drain();

        // Random phases over all policies and modes, the undefined one included
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_POLICY, (ph == 4) ? 32'd3 : ph % 3);
            write_reg(REG_MODE, ph % 2);
            for (int n = 0; n < 12; n++) begin
                x = rand_item();
                send(x);
            end
            drain();
        end

        rx_enable = 0;
        if (error_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end
endmodule
